// ===== hw/rtl/snt_pkg.sv =====
// ----------------------------------------------------------------------------
// Strongest-neighbour table package
// Shared types, constants and helpers for the neighbour table core.
// ----------------------------------------------------------------------------
`default_nettype none

package snt_pkg;

	localparam int SLOTS_DEF = 20;
	localparam int MAC_W     = 48;
	localparam int SLOT_W    = 5;

	// Result codes.
	typedef enum logic [2:0] {
		ST_OWNER   = 3'd0,
		ST_REFRESH = 3'd1,
		ST_KEPT    = 3'd2,
		ST_INSERT  = 3'd3,
		ST_REPLACE = 3'd4,
		ST_DROP    = 3'd5,
		ST_READ    = 3'd6
	} status_t;

	// Request kinds carried on the input user field.
	typedef enum logic {
		ACT_OBSERVE = 1'b0,
		ACT_READ    = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_RDWAIT,
		S_SCAN,
		S_FINISH
	} state_t;

	// One table entry; an all-zero entry is an empty slot.
	typedef struct packed {
		logic [MAC_W-1:0] mac;
		logic [7:0]       quality;
		logic signed [7:0] strength;
	} entry_t;

	// Result handed from the controller to the output register.
	typedef struct packed {
		logic [7:0]        quality;
		logic signed [7:0] strength;
		logic [MAC_W-1:0]  mac;
		logic              valid;
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} res_t;

	function automatic res_t mk_res(status_t st, logic [SLOT_W-1:0] slot, entry_t e);
		res_t r;
		r.status   = st;
		r.slot     = slot;
		r.valid    = (e != '0);
		r.mac      = e.mac;
		r.strength = e.strength;
		r.quality  = e.quality;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/snt_mem.sv =====
// ----------------------------------------------------------------------------
// Neighbour slot memory
// Single write, single read memory with registered read data and a valid bit
// per slot, so that a slot never written since reset reads as empty.
// ----------------------------------------------------------------------------
`default_nettype none

module snt_mem import snt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int AW = $clog2(SLOTS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t           mem_q [SLOTS];
	logic [SLOTS-1:0] valid_q;
	entry_t           rd_s1;
	logic             rvld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_s1 <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvld_s1 <= valid_q[raddr];
		end
	end

	assign rdata = rvld_s1 ? rd_s1 : entry_t'('0);

endmodule

`default_nettype wire

// ===== hw/rtl/snt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Neighbour table controller
// Takes one request, walks the slot memory one slot a cycle and writes back
// the refreshed, inserted or replacing entry.
// ----------------------------------------------------------------------------
`default_nettype none

module snt_ctrl import snt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int AW = $clog2(SLOTS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [MAC_W-1:0]  owner_mac,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire action_t           action,
	input  wire logic [MAC_W-1:0]  station_mac,
	input  wire logic signed [7:0] strength,
	input  wire logic [7:0]        quality,
	input  wire logic [SLOT_W-1:0] slot_index,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output res_t                   res,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output entry_t                 mem_wdata,
	output logic [AW-1:0]          mem_raddr,
	input  wire entry_t            mem_rdata
);

	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

	state_t            state_q, state_d;
	action_t           act_q;
	logic [MAC_W-1:0]  mac_q;
	logic signed [7:0] str_q;
	logic [7:0]        qual_q;
	logic [SLOT_W-1:0] idx_q;
	res_t              res_q, res_d;

	logic [AW-1:0]     k_q;
	logic              iss_done_q;
	logic              chk_s1;
	logic [AW-1:0]     slot_s1;
	logic signed [7:0] min_q;
	logic [AW-1:0]     min_slot_q;

	entry_t            new_ent;
	logic              in_range;
	logic              occupied;
	logic              match;
	logic              lower;
	logic signed [7:0] cand_min;
	logic [AW-1:0]     cand_slot;

	assign new_ent   = '{mac: mac_q, quality: qual_q, strength: str_q};
	assign in_range  = (32'(idx_q) < SLOTS);
	assign occupied  = (mem_rdata != '0);
	assign match     = occupied && (mem_rdata.mac == mac_q);
	assign lower     = ($signed(mem_rdata.strength) < min_q);
	assign cand_min  = lower ? $signed(mem_rdata.strength) : min_q;
	assign cand_slot = lower ? slot_s1 : min_slot_q;
	assign mem_wdata = new_ent;
	assign res       = res_q;

	always_comb begin
		state_d   = state_q;
		res_d     = res_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = slot_s1;
		mem_raddr = k_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (act_q == ACT_READ) begin
					mem_raddr = in_range ? AW'(idx_q) : '0;
					state_d   = S_RDWAIT;
				end else if (mac_q == owner_mac) begin
					res_d   = mk_res(ST_OWNER, '0, '0);
					state_d = S_FINISH;
				end else if (mac_q == '0) begin
					res_d   = mk_res(ST_DROP, '0, '0);
					state_d = S_FINISH;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_RDWAIT: begin
				res_d   = mk_res(ST_READ, idx_q, in_range ? mem_rdata : entry_t'('0));
				state_d = S_FINISH;
			end
			S_SCAN: begin
				if (chk_s1) begin
					if (match) begin
						if (str_q > $signed(mem_rdata.strength)) begin
							mem_we = 1'b1;
							res_d  = mk_res(ST_REFRESH, SLOT_W'(slot_s1), new_ent);
						end else begin
							res_d = mk_res(ST_KEPT, SLOT_W'(slot_s1), mem_rdata);
						end
						state_d = S_FINISH;
					end else if (!occupied) begin
						mem_we  = 1'b1;
						res_d   = mk_res(ST_INSERT, SLOT_W'(slot_s1), new_ent);
						state_d = S_FINISH;
					end else if (slot_s1 == LAST) begin
						// Table full: replace the first weakest entry if it is negative
						// and weaker than the new observation.
						if (cand_min < 0 && cand_min < str_q) begin
							mem_we    = 1'b1;
							mem_waddr = cand_slot;
							res_d     = mk_res(ST_REPLACE, SLOT_W'(cand_slot), new_ent);
						end else begin
							res_d = mk_res(ST_DROP, '0, '0);
						end
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (state_q == S_IDLE && req_valid) begin
			act_q  <= action;
			mac_q  <= station_mac;
			str_q  <= strength;
			qual_q <= quality;
			idx_q  <= slot_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			iss_done_q <= 1'b0;
			chk_s1     <= 1'b0;
			slot_s1    <= '0;
			min_q      <= '0;
			min_slot_q <= '0;
		end else if (state_q == S_DECIDE) begin
			k_q        <= '0;
			iss_done_q <= 1'b0;
			chk_s1     <= 1'b0;
			min_q      <= '0;
			min_slot_q <= '0;
		end else if (state_q == S_SCAN) begin
			chk_s1  <= !iss_done_q;
			slot_s1 <= k_q;
			if (!iss_done_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == LAST) begin
					iss_done_q <= 1'b1;
				end
			end
			if (chk_s1 && occupied && !match) begin
				min_q      <= cand_min;
				min_slot_q <= cand_slot;
			end
		end else begin
			chk_s1 <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/strongest_neighbour_table_core.sv =====
// ----------------------------------------------------------------------------
// Strongest-neighbour table core
// Table of neighbour stations keyed by MAC, kept in a slot memory.
// ----------------------------------------------------------------------------
// Usage. Requests enter on the s_ stream: s_tuser selects an observation (0)
// or a slot read (1), s_tdata carries the MAC, strength, quality and slot
// index. Every request yields exactly one result on the m_ stream, carrying
// a status code, the slot touched and the entry held in that slot afterwards.
// The owner MAC is to be written through the APB port while the block is idle.
//
// Timing. One request is handled at a time. A read passes the decide state,
// the slot memory's registered read and the result register; an owner or
// zero-MAC observation passes the decide state and the result register.
// Other observations walk the slot memory one slot per cycle through its
// single read port, the write-back sharing the cycle of the deciding
// comparison. The next request is taken once the output register holds the
// result. The block itself does not enforce the idle rule for owner writes.
//
// Reset clears the owner MAC and marks every slot empty at once through a
// valid bit per slot; no clearing pass is needed. When the receiver stalls,
// the result waits in the output register; one further request can be
// accepted and worked on, and the core then holds in its final state until
// the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module strongest_neighbour_table_core import snt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata, from bit 0: station_mac[47:0], strength[7:0], quality[7:0],
	// slot_index[4:0], zero fill
	input  wire logic [71:0] s_tdata,
	// s_tuser: action (0 observe, 1 read)
	input  wire logic        s_tuser,
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata, from bit 0: status[2:0], slot_used[4:0], entry_valid,
	// entry_mac[47:0], entry_strength[7:0], entry_quality[7:0], zero fill
	output logic [79:0]      m_tdata,
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	localparam int AW = $clog2(SLOTS);

	// Only register: the owner MAC at byte address 0; bit 3 selects the
	// 8-byte register, higher indexes are not implemented.
	logic [MAC_W-1:0] owner_q;

	assign pready = 1'b1;
	assign prdata = (paddr[3] == 1'b0) ? {16'd0, owner_q} : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[3] == 1'b0) begin
			owner_q <= pwdata[MAC_W-1:0];
		end
	end

	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;
	action_t       action;

	assign action = action_t'(s_tuser);

	snt_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.owner_mac  (owner_q),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.action     (action),
		.station_mac(s_tdata[47:0]),
		.strength   (s_tdata[55:48]),
		.quality    (s_tdata[63:56]),
		.slot_index (s_tdata[68:64]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	snt_mem #(
		.SLOTS(SLOTS)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: decouples the controller from a stalling receiver.
	logic out_valid_q;
	res_t out_q;

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q};

endmodule

`default_nettype wire

// ===== hw/rtl/snt_checker.sv =====
// ----------------------------------------------------------------------------
// Neighbour table port checker
// Concurrent checks on the ports of the core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module snt_checker import snt_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One request at a time: the core is busy in the cycle after acceptance.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// Ignored and dropped observations report no slot and no entry.
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == ST_OWNER || m_tdata[2:0] == ST_DROP)
		|-> m_tdata[79:3] == '0)
		else $error("entry reported for ignored or dropped observation");

	// Any result other than a read reports a filled slot when it touches one.
	a_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == ST_REFRESH || m_tdata[2:0] == ST_KEPT ||
		m_tdata[2:0] == ST_INSERT || m_tdata[2:0] == ST_REPLACE)
		|-> m_tdata[8] && m_tdata[56:9] != '0)
		else $error("touched slot reported empty");

endmodule

bind strongest_neighbour_table_core snt_checker u_snt_checker (.*);

`default_nettype wire

// ===== sim/strongest_neighbour_table_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Strongest-neighbour table core testbench
// Sends observation and slot-read requests with bursty timing and a stalling
// receiver. Each result is checked field by field against a scoreboard model
// of the table, across several owner MAC settings.
// ----------------------------------------------------------------------------

module strongest_neighbour_table_core_test;
	import snt_pkg::*;

	localparam int         SLOTS          = SLOTS_DEF;
	localparam logic [3:0] REG_OWNER_MAC  = 4'h0;
	localparam int         PHASE_REQUESTS = 220;
	localparam int         POOL_SIZE      = 32;
	// The longest observation walks every slot; the settle time covers it with margin.
	localparam int         SETTLE_CYCLES  = 2 * (SLOTS + 4);

	// Receiver behaviour, chosen afresh for each stretch of cycles.
	typedef enum int {
		RX_STREAM,
		RX_RANDOM,
		RX_THROTTLED,
		RX_PERIODIC
	} rx_mode_t;

	// One result as the core reports it, unpacked from m_tdata.
	typedef struct packed {
		status_t           status;
		logic [4:0]        slot;
		logic              valid;
		logic [47:0]       mac;
		logic signed [7:0] strength;
		logic [7:0]        quality;
	} neighbour_report_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// s_tdata, from bit 0: station_mac[47:0], strength[7:0], quality[7:0],
	// slot_index[4:0], zero fill
	logic [71:0] s_tdata;
	// s_tuser: action (0 observe, 1 read)
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// m_tdata, from bit 0: status[2:0], slot_used[4:0], entry_valid,
	// entry_mac[47:0], entry_strength[7:0], entry_quality[7:0], zero fill
	logic [79:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	// Scoreboard copy of the slot store and the owner register.
	entry_t            neighbour_model [SLOTS];
	logic [47:0]       owner_model;
	// Results owed by the core, oldest first.
	neighbour_report_t expected_reports [$];
	logic [47:0]       station_pool [POOL_SIZE];
	int                fault_count;
	int                burst_left;

	strongest_neighbour_table_core #(.SLOTS(SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Safety net: the slowest legal run is far shorter than this.
	initial begin
		#10_000_000;
		$display("strongest_neighbour_table_core_test NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Scoreboard model
	// ------------------------------------------------------------------------

	function automatic neighbour_report_t describe_slot(status_t st, int slot, entry_t e);
		neighbour_report_t r;
		r.status   = st;
		r.slot     = slot[4:0];
		r.valid    = (e != '0);
		r.mac      = e.mac;
		r.strength = e.strength;
		r.quality  = e.quality;
		return r;
	endfunction

	// Applies one request to the model table and returns the result it owes.
	function automatic neighbour_report_t apply_to_table(action_t act, logic [47:0] mac,
			logic signed [7:0] strength, logic [7:0] quality, logic [4:0] idx);
		entry_t e;
		entry_t fresh;
		int     weakest;
		int     weakest_slot;
		bit     have_weakest;
		fresh.mac      = mac;
		fresh.quality  = quality;
		fresh.strength = strength;
		weakest        = 0;
		weakest_slot   = 0;
		have_weakest   = 1'b0;
		if (act == ACT_READ) begin
			// Indexes past the end of the table report an empty entry.
			e = (idx < SLOTS) ? neighbour_model[idx] : entry_t'('0);
			return describe_slot(ST_READ, idx, e);
		end
		// The owner check comes first, so with owner zero a zero MAC is ignored.
		if (mac == owner_model)
			return describe_slot(ST_OWNER, 0, '0);
		if (mac == '0)
			return describe_slot(ST_DROP, 0, '0);
		for (int k = 0; k < SLOTS; k++) begin
			e = neighbour_model[k];
			if (e != '0 && e.mac == mac) begin
				if ($signed(strength) > $signed(e.strength)) begin
					neighbour_model[k] = fresh;
					return describe_slot(ST_REFRESH, k, fresh);
				end
				return describe_slot(ST_KEPT, k, e);
			end
			if (e == '0) begin
				neighbour_model[k] = fresh;
				return describe_slot(ST_INSERT, k, fresh);
			end
			// Only strictly weaker, negative entries are candidates, so ties
			// leave the first weakest slot chosen.
			if ($signed(e.strength) < weakest) begin
				weakest      = $signed(e.strength);
				weakest_slot = k;
				have_weakest = 1'b1;
			end
		end
		if (have_weakest && weakest < $signed(strength)) begin
			neighbour_model[weakest_slot] = fresh;
			return describe_slot(ST_REPLACE, weakest_slot, fresh);
		end
		return describe_slot(ST_DROP, 0, '0);
	endfunction

	function automatic logic [47:0] random_mac();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[47:0];
	endfunction

	// Mostly negative strengths, so that replacements keep happening in a
	// table that can never shrink.
	function automatic logic signed [7:0] random_strength();
		int pick;
		int v;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			v = int'($urandom_range(0, 127)) - 128;
		else if (pick < 92)
			v = -128;
		else
			v = $urandom_range(0, 255);
		return v[7:0];
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Presents one request and waits for it to be taken. The sender works in
	// bursts; at the end of a burst it may drop tvalid for a random gap.
	task automatic send_request(action_t act, logic [47:0] mac, logic signed [7:0] strength,
			logic [7:0] quality, logic [4:0] idx);
		int gap;
		@(negedge clk);
		s_tuser  = act;
		s_tdata  = {3'b000, idx, quality, strength, mac};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		expected_reports.push_back(apply_to_table(act, mac, strength, quality, idx));
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// Every request owes exactly one result, so an empty scoreboard means
	// the core is idle and may be reconfigured.
	task automatic wait_until_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
	endtask

	// Writes the owner register and reads it straight back.
	task automatic write_owner(logic [63:0] value);
		logic [63:0] seen;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = REG_OWNER_MAC;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		owner_model = value[47:0];
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		seen = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (seen[47:0] !== owner_model) begin
			fault_count++;
			if (fault_count <= 10)
				$display("%0t owner register reads %h after writing %h", $time,
					seen[47:0], owner_model);
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	// The receiver switches between streaming, random, heavily throttled and
	// periodic acceptance for stretches of random length.
	initial begin
		rx_mode_t mode;
		int       stretch;
		int       tick;
		m_tready = 1'b0;
		tick     = 0;
		forever begin
			mode    = rx_mode_t'($urandom_range(0, 3));
			stretch = $urandom_range(16, 160);
			repeat (stretch) begin
				@(negedge clk);
				tick++;
				case (mode)
					RX_STREAM:    m_tready = 1'b1;
					RX_RANDOM:    m_tready = $urandom_range(0, 1);
					RX_THROTTLED: m_tready = ($urandom_range(0, 7) == 0);
					default:      m_tready = (tick % 4 != 3);
				endcase
			end
		end
	end

	task automatic report_fault(string what, neighbour_report_t want, neighbour_report_t got);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%0t %s: expected st=%0d slot=%0d v=%0b mac=%h str=%0d q=%0d",
				$time, what, want.status, want.slot, want.valid, want.mac,
				want.strength, want.quality);
			$display("%0t %s: got      st=%0d slot=%0d v=%0b mac=%h str=%0d q=%0d",
				$time, what, got.status, got.slot, got.valid, got.mac,
				got.strength, got.quality);
		end
	endtask

	// Each result taken by the receiver is matched against the oldest
	// expectation.
	always @(posedge clk) begin : result_check
		neighbour_report_t got;
		neighbour_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status   = status_t'(m_tdata[2:0]);
			got.slot     = m_tdata[7:3];
			got.valid    = m_tdata[8];
			got.mac      = m_tdata[56:9];
			got.strength = m_tdata[64:57];
			got.quality  = m_tdata[72:65];
			if (expected_reports.size() == 0) begin
				report_fault("result with no request outstanding", '0, got);
			end else begin
				want = expected_reports.pop_front();
				if (got.status !== want.status || got.slot !== want.slot ||
						got.valid !== want.valid || got.mac !== want.mac ||
						got.strength !== want.strength || got.quality !== want.quality)
					report_fault("result differs", want, got);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Straight after reset: the owner is zero, so a zero MAC counts as the
	// owner; reads of empty slots and of indexes past the table.
	task automatic test_empty_table();
		send_request(ACT_OBSERVE, '0, -8'sd40, 8'd9, 5'd0);
		send_request(ACT_READ, random_mac(), 8'sd127, 8'hff, 5'd0);
		send_request(ACT_READ, '0, '0, '0, 5'(SLOTS - 1));
		send_request(ACT_READ, random_mac(), -8'sd128, 8'h00, 5'd31);
		send_request(ACT_READ, random_mac(), 8'sd3, 8'h5a, 5'(SLOTS));
		wait_until_idle();
		// Upper write bits must be discarded by the 48-bit register.
		write_owner(64'hffff_ffff_ffff_ffff);
		send_request(ACT_OBSERVE, '0, 8'sd5, 8'd1, 5'd31);
		send_request(ACT_OBSERVE, 48'hffff_ffff_ffff, 8'sd127, 8'hff, 5'd0);
	endtask

	// One station: first insert, a weaker and an equal sighting are kept,
	// a stronger one refreshes the entry.
	task automatic test_refresh_and_keep();
		logic [47:0] station;
		station = random_mac();
		send_request(ACT_OBSERVE, station, -8'sd128, 8'h00, 5'd0);
		send_request(ACT_OBSERVE, station, -8'sd128, 8'hff, 5'd17);
		send_request(ACT_OBSERVE, station, 8'sd127, 8'hff, 5'd0);
		send_request(ACT_OBSERVE, station, 8'sd127, 8'h00, 5'd0);
		send_request(ACT_OBSERVE, station, 8'sd126, 8'h33, 5'd0);
		send_request(ACT_READ, '0, '0, '0, 5'd0);
	endtask

	// Fills the rest of the table with negative entries, two of them tied
	// at the weakest strength, then tests replacement in a full table.
	task automatic test_fill_and_replace();
		int v;
		for (int k = 1; k < SLOTS; k++) begin
			v = (k == 3 || k == 7) ? -128 : -int'($urandom_range(1, 127));
			send_request(ACT_OBSERVE, random_mac(), v[7:0], 8'($urandom_range(0, 255)),
				5'($urandom_range(0, 31)));
		end
		// Not stronger than the weakest entry: dropped.
		send_request(ACT_OBSERVE, random_mac(), -8'sd128, 8'h11, 5'd0);
		// The first of the tied weakest entries goes, then the second.
		send_request(ACT_OBSERVE, random_mac(), -8'sd100, 8'h22, 5'd0);
		send_request(ACT_OBSERVE, random_mac(), -8'sd50, 8'h44, 5'd0);
		send_request(ACT_READ, '0, '0, '0, 5'(SLOTS - 1));
	endtask

	// Random traffic in phases, each under its own owner MAC. Most sightings
	// come from a small pool of stations or from the table itself, so that
	// refreshes and replacements keep happening.
	task automatic test_random_traffic();
		int                phase_requests;
		int                pick;
		action_t           act;
		logic [47:0]       mac;
		logic signed [7:0] strength;
		logic [7:0]        quality;
		logic [4:0]        idx;
		foreach (station_pool[i])
			station_pool[i] = random_mac();
		for (int phase = 0; phase < 5; phase++) begin
			wait_until_idle();
			case (phase)
				0: write_owner({$urandom(), $urandom()});
				1: write_owner({16'h0, neighbour_model[$urandom_range(0, SLOTS - 1)].mac});
				2: write_owner('0);
				3: write_owner({16'($urandom()), station_pool[0]});
				default: write_owner({$urandom(), $urandom()});
			endcase
			phase_requests = 0;
			while (phase_requests < PHASE_REQUESTS) begin
				pick     = $urandom_range(0, 99);
				act      = ACT_OBSERVE;
				mac      = random_mac();
				strength = random_strength();
				quality  = $urandom_range(0, 255);
				idx      = $urandom_range(0, 31);
				if (pick < 15)
					act = ACT_READ;
				else if (pick < 55)
					mac = station_pool[$urandom_range(0, POOL_SIZE - 1)];
				else if (pick < 70)
					mac = neighbour_model[$urandom_range(0, SLOTS - 1)].mac;
				else if (pick < 90)
					mac = random_mac();
				else if (pick < 95)
					mac = owner_model;
				else
					mac = '0;
				// Owner sightings are ignored by the core and do not count.
				if (!(act == ACT_OBSERVE && mac == owner_model))
					phase_requests++;
				send_request(act, mac, strength, quality, idx);
			end
		end
	endtask

	// Lifts every entry to full strength, so that no entry is negative and
	// any unknown station is dropped, then reads back every index.
	task automatic test_saturated_table();
		wait_until_idle();
		write_owner({$urandom(), $urandom()});
		for (int k = 0; k < SLOTS; k++)
			send_request(ACT_OBSERVE, neighbour_model[k].mac, 8'sd127,
				8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
		send_request(ACT_OBSERVE, random_mac(), 8'sd127, 8'hff, 5'd0);
		send_request(ACT_OBSERVE, random_mac(), -8'sd1, 8'h01, 5'd0);
		for (int k = 0; k < 32; k++)
			send_request(ACT_READ, random_mac(), random_strength(), 8'($urandom_range(0, 255)),
				5'(k));
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = ACT_OBSERVE;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = REG_OWNER_MAC;
		pwdata      = '0;
		owner_model = '0;
		fault_count = 0;
		burst_left  = 1;
		foreach (neighbour_model[k])
			neighbour_model[k] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_refresh_and_keep();
		test_fill_and_replace();
		test_random_traffic();
		test_saturated_table();

		// Let any stray result surface before judging the run.
		wait_until_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && expected_reports.size() == 0)
			$display("strongest_neighbour_table_core_test OK");
		else
			$display("strongest_neighbour_table_core_test NOT OK");
		$finish;
	end

endmodule
